// ===== hw/rtl/pid_speed_with_feedforward_unit_assert.svh =====
// assertion helpers shared by the speed controller modules
// expects clk_i and rst_ni in the scope of use
`ifndef PID_SPEED_WITH_FEEDFORWARD_UNIT_ASSERT_SVH
`define PID_SPEED_WITH_FEEDFORWARD_UNIT_ASSERT_SVH

// checked only outside reset
`define PSF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked on every edge, reset included
`define PSF_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== hw/rtl/pid_sf_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package pid_sf_pkg;

  // integral clamp magnitude
  localparam int ISUM_MAX = 300;

  // register index, byte address is 4 * index
  typedef enum logic [2:0] {
    REG_GAIN_PROP   = 3'd0,
    REG_GAIN_INTEG  = 3'd1,
    REG_GAIN_DERIV  = 3'd2,
    REG_FF_SCALE    = 3'd3,
    REG_DRIVE_LIMIT = 3'd4
  } reg_idx_e;

  typedef struct packed {
    logic signed [15:0] gain_prop;
    logic signed [15:0] gain_integ;
    logic signed [15:0] gain_deriv;
    logic signed [15:0] ff_scale;
    logic        [14:0] drive_limit;
  } cfg_t;

  // error stage payload
  typedef struct packed {
    logic               zero;
    logic signed [15:0] target;
    logic signed [16:0] err;
    logic signed [17:0] deriv;
    logic signed [9:0]  isum;
  } err_stage_t;

  // product stage payload
  typedef struct packed {
    logic               zero;
    logic signed [31:0] ff;
    logic signed [32:0] prop;
    logic signed [25:0] integ;
    logic signed [33:0] deriv;
  } prod_stage_t;

endpackage
`default_nettype wire

// ===== hw/rtl/pid_sf_cfg.sv =====
`timescale 1ns / 1ps
`default_nettype none
module pid_sf_cfg (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [4:0]        paddr,
  input  wire logic [31:0]       pwdata,
  output logic      [31:0]       prdata,
  output pid_sf_pkg::cfg_t       cfg_o
);

  pid_sf_pkg::cfg_t   cfg_q;
  pid_sf_pkg::reg_idx_e idx;
  logic               wr_en;

  assign idx   = pid_sf_pkg::reg_idx_e'(paddr[4:2]);
  assign wr_en = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (wr_en) begin
      case (idx)
        pid_sf_pkg::REG_GAIN_PROP:   cfg_q.gain_prop   <= pwdata[15:0];
        pid_sf_pkg::REG_GAIN_INTEG:  cfg_q.gain_integ  <= pwdata[15:0];
        pid_sf_pkg::REG_GAIN_DERIV:  cfg_q.gain_deriv  <= pwdata[15:0];
        pid_sf_pkg::REG_FF_SCALE:    cfg_q.ff_scale    <= pwdata[15:0];
        pid_sf_pkg::REG_DRIVE_LIMIT: cfg_q.drive_limit <= pwdata[14:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      pid_sf_pkg::REG_GAIN_PROP:   prdata = {16'h0000, cfg_q.gain_prop};
      pid_sf_pkg::REG_GAIN_INTEG:  prdata = {16'h0000, cfg_q.gain_integ};
      pid_sf_pkg::REG_GAIN_DERIV:  prdata = {16'h0000, cfg_q.gain_deriv};
      pid_sf_pkg::REG_FF_SCALE:    prdata = {16'h0000, cfg_q.ff_scale};
      pid_sf_pkg::REG_DRIVE_LIMIT: prdata = {17'h00000, cfg_q.drive_limit};
      default:                     prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule
`default_nettype wire

// ===== hw/rtl/pid_sf_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "pid_speed_with_feedforward_unit_assert.svh"
module pid_sf_front (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   in_valid_i,
  output logic                        in_ready_o,
  input  wire logic                   req_type_i,
  input  wire logic signed [15:0]     target_i,
  input  wire logic signed [15:0]     measured_i,
  output logic                        out_valid_o,
  input  wire logic                   out_ready_i,
  output pid_sf_pkg::err_stage_t      out_o
);

  localparam logic signed [17:0] IsumHi = 18'(pid_sf_pkg::ISUM_MAX);
  localparam logic signed [17:0] IsumLo = -IsumHi;

  // input register
  logic               v0_q;
  logic               req0_q;
  logic signed [15:0] tgt0_q;
  logic signed [15:0] meas0_q;
  // error stage register
  logic               v1_q;
  pid_sf_pkg::err_stage_t s1_q, s1_d;
  // controller state
  logic signed [9:0]  err_sum_q, err_sum_d;
  logic signed [16:0] prev_err_q, prev_err_d;

  logic               ready0, ready1, adv0;
  logic signed [16:0] err;
  logic signed [17:0] deriv;
  logic signed [17:0] isum_raw;
  logic signed [9:0]  isum;
  logic               zero;

  assign ready1     = !v1_q || out_ready_i;
  assign ready0     = !v0_q || ready1;
  assign adv0       = v0_q && ready1;
  assign in_ready_o = ready0;

  always_comb begin
    zero     = req0_q | tgt0_q[15] | (tgt0_q == 16'sd0);
    err      = {tgt0_q[15], tgt0_q} - {meas0_q[15], meas0_q};
    deriv    = {err[16], err} - {prev_err_q[16], prev_err_q};
    isum_raw = {{8{err_sum_q[9]}}, err_sum_q} + {err[16], err};
    if (isum_raw > IsumHi) begin
      isum = IsumHi[9:0];
    end else if (isum_raw < IsumLo) begin
      isum = IsumLo[9:0];
    end else begin
      isum = isum_raw[9:0];
    end
    s1_d.zero   = zero;
    s1_d.target = tgt0_q;
    s1_d.err    = err;
    s1_d.deriv  = deriv;
    s1_d.isum   = isum;
    if (zero) begin
      err_sum_d  = '0;
      prev_err_d = '0;
    end else begin
      err_sum_d  = isum;
      prev_err_d = err;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q       <= 1'b0;
      v1_q       <= 1'b0;
      err_sum_q  <= '0;
      prev_err_q <= '0;
    end else begin
      if (ready0) v0_q <= in_valid_i;
      if (ready1) v1_q <= v0_q;
      // state moves exactly once per item, in order
      if (adv0) begin
        err_sum_q  <= err_sum_d;
        prev_err_q <= prev_err_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready0) begin
      req0_q  <= req_type_i;
      tgt0_q  <= target_i;
      meas0_q <= measured_i;
    end
    if (ready1) s1_q <= s1_d;
  end

  assign out_valid_o = v1_q;
  assign out_o       = s1_q;

  `PSF_ASSERT(a_isum_range,
    (err_sum_q <= 10'sd300) && (err_sum_q >= -10'sd300),
    "integral left its clamp range")
  `PSF_ASSERT(a_clear_state,
    (adv0 && zero) |=> (err_sum_q == 10'sd0) && (prev_err_q == 17'sd0),
    "state not cleared after clear or stop")
  `PSF_ASSERT(a_prev_err,
    (adv0 && !zero) |=> (prev_err_q == s1_q.err),
    "last error does not match the error handed on")

endmodule
`default_nettype wire

// ===== hw/rtl/pid_sf_mult.sv =====
`timescale 1ns / 1ps
`default_nettype none
module pid_sf_mult (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire pid_sf_pkg::cfg_t       cfg_i,
  input  wire logic                   in_valid_i,
  output logic                        in_ready_o,
  input  wire pid_sf_pkg::err_stage_t in_i,
  output logic                        out_valid_o,
  input  wire logic                   out_ready_i,
  output pid_sf_pkg::prod_stage_t     out_o
);

  logic                    v_q;
  pid_sf_pkg::prod_stage_t p_q, p_d;

  // four independent products, each one multiplier
  always_comb begin
    p_d.zero  = in_i.zero;
    p_d.ff    = $signed(in_i.target) * $signed(cfg_i.ff_scale);
    p_d.prop  = $signed(in_i.err)    * $signed(cfg_i.gain_prop);
    p_d.integ = $signed(in_i.isum)   * $signed(cfg_i.gain_integ);
    p_d.deriv = $signed(in_i.deriv)  * $signed(cfg_i.gain_deriv);
  end

  assign in_ready_o = !v_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (in_ready_o) begin
      v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o) p_q <= p_d;
  end

  assign out_valid_o = v_q;
  assign out_o       = p_q;

endmodule
`default_nettype wire

// ===== hw/rtl/pid_sf_out.sv =====
`timescale 1ns / 1ps
`default_nettype none
module pid_sf_out (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic [14:0]             drive_limit_i,
  input  wire logic                    in_valid_i,
  output logic                         in_ready_o,
  input  wire pid_sf_pkg::prod_stage_t in_i,
  output logic                         out_valid_o,
  input  wire logic                    out_ready_i,
  output logic [14:0]                  drive_o
);

  logic               v_q;
  logic [14:0]        drive_q, drive_d;
  logic signed [41:0] ff_w, prop_w, integ_w, deriv_w, sum_w, lim_w;

  // signed q33.8 sum (8 fraction bits) and clamp to 0..limit
  always_comb begin
    ff_w    = {{2{in_i.ff[31]}}, in_i.ff, 8'h00};
    prop_w  = {{9{in_i.prop[32]}}, in_i.prop};
    integ_w = {{16{in_i.integ[25]}}, in_i.integ};
    deriv_w = {{8{in_i.deriv[33]}}, in_i.deriv};
    sum_w   = ff_w + prop_w + integ_w + deriv_w;
    lim_w   = {19'h00000, drive_limit_i, 8'h00};
    if (in_i.zero || sum_w[41]) begin
      drive_d = '0;
    end else if (sum_w > lim_w) begin
      drive_d = drive_limit_i;
    end else begin
      drive_d = sum_w[22:8];
    end
  end

  assign in_ready_o = !v_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (in_ready_o) begin
      v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o) drive_q <= drive_d;
  end

  assign out_valid_o = v_q;
  assign drive_o     = drive_q;

endmodule
`default_nettype wire

// ===== hw/rtl/pid_speed_with_feedforward_unit.sv =====
// order: an input transfer passes the input, error, multiplier and output registers in turn
// throughput: one item per cycle while m_axis_tready holds, four-stage pipe, per-stage ready
// stages: input register, error/integral stage, multiplier stage, sum/clamp output register
// reset: rst_ni async active low clears gains, limit, integral, last error and all valids
// no clearing pass, the block takes items from the first cycle after reset
`timescale 1ns / 1ps
`default_nettype none
`include "pid_speed_with_feedforward_unit_assert.svh"
module pid_speed_with_feedforward_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // input stream
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,  // [15:0] target_speed, [31:16] measured_speed
  input  wire logic        s_axis_tuser,  // [0] req_type
  // result stream
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [15:0]      m_axis_tdata,  // [14:0] drive_value, [15] zero pad
  // register port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  pid_sf_pkg::cfg_t        cfg;
  pid_sf_pkg::err_stage_t  err_stage;
  pid_sf_pkg::prod_stage_t prod_stage;
  logic                    err_valid, err_ready;
  logic                    prod_valid, prod_ready;
  logic [14:0]             drive;
  logic                    limit_wr;

  // register file, writes complete in the access phase
  assign pready = 1'b1;

  pid_sf_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg_o   (cfg)
  );

  // input register, error, derivative, saturating integral and controller state
  pid_sf_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .req_type_i  (s_axis_tuser),
    .target_i    (s_axis_tdata[15:0]),
    .measured_i  (s_axis_tdata[31:16]),
    .out_valid_o (err_valid),
    .out_ready_i (err_ready),
    .out_o       (err_stage)
  );

  // feedforward and gain products
  pid_sf_mult u_mult (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (err_valid),
    .in_ready_o  (err_ready),
    .in_i        (err_stage),
    .out_valid_o (prod_valid),
    .out_ready_i (prod_ready),
    .out_o       (prod_stage)
  );

  // sum, clamp and output register
  pid_sf_out u_out (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .drive_limit_i (cfg.drive_limit),
    .in_valid_i    (prod_valid),
    .in_ready_o    (prod_ready),
    .in_i          (prod_stage),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .drive_o       (drive)
  );

  assign m_axis_tdata = {1'b0, drive};

  // access phase of a write to the limit register
  assign limit_wr = psel && penable && pwrite && (paddr[4:2] == pid_sf_pkg::REG_DRIVE_LIMIT);

  // checks that a presented result does not exceed the limit now in force
  `PSF_ASSERT(a_drive_le_limit, m_axis_tvalid |-> (drive <= cfg.drive_limit),
    "drive above limit")
  // with the output register empty every stage can take a transfer
  `PSF_ASSERT(a_empty_ready, !m_axis_tvalid |-> s_axis_tready,
    "input stalled with empty output")
  // a limit write lands on the next edge
  `PSF_ASSERT(a_limit_write, limit_wr |=> (cfg.drive_limit == $past(pwdata[14:0])),
    "limit write lost")

endmodule
`default_nettype wire
